// File: rtl/core/sdm_pkg.sv
package sdm_pkg;

    localparam int INDEX_WIDTH    = 16;
    localparam int VALUE_WIDTH    = 32;
    localparam int FRAC_BITS      = 16;
    localparam int LEN_WIDTH      = 12;
    localparam int MAX_ROW_LENGTH = 4095;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_MERGE_OP = 2'd0;

    typedef enum logic [1:0] {
        OP_SUM     = 2'd0,
        OP_PRODUCT = 2'd1,
        OP_MAX_MAG = 2'd2,
        OP_MIN_MAG = 2'd3
    } merge_op_t;

    typedef logic [INDEX_WIDTH-1:0]        index_t;
    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [LEN_WIDTH-1:0]          len_t;

    typedef struct packed {
        index_t index;
        value_t value;
        logic   row_end;
        logic   no_entry;
    } item_t;

    typedef struct packed {
        index_t index;
        value_t value;
        logic   row_end;
        logic   empty_row;
        len_t   length;
    } result_t;

    typedef struct packed {
        logic [1:0] n;
        result_t    first;
        result_t    second;
    } push_t;

    typedef struct packed {
        logic [FIFO_CNT_W-1:0] count;
        logic                  space_ok;
    } fifo_stat_t;

    localparam value_t VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam value_t VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    function automatic value_t sat_add(value_t a, value_t b);
        logic signed [VALUE_WIDTH:0] sum;
        sum = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
        if (sum[VALUE_WIDTH] != sum[VALUE_WIDTH-1])
        begin
            return sum[VALUE_WIDTH] ? VAL_MIN : VAL_MAX;
        end
        return sum[VALUE_WIDTH-1:0];
    endfunction

    function automatic value_t sat_abs(value_t x);
        if (x == VAL_MIN)
        begin
            return VAL_MAX;
        end
        return x[VALUE_WIDTH-1] ? -x : x;
    endfunction

    function automatic value_t sat_mul(value_t a, value_t b);
        logic                       neg;
        logic [VALUE_WIDTH-1:0]     ma;
        logic [VALUE_WIDTH-1:0]     mb;
        logic [2*VALUE_WIDTH-1:0]   prod;
        logic [2*VALUE_WIDTH-1:0]   q;
        logic [2*VALUE_WIDTH-1:0]   limit;
        neg   = a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1];
        ma    = a[VALUE_WIDTH-1] ? -a : a;
        mb    = b[VALUE_WIDTH-1] ? -b : b;
        prod  = {{VALUE_WIDTH{1'b0}}, ma} * {{VALUE_WIDTH{1'b0}}, mb};
        q     = prod >> FRAC_BITS;
        limit = {{VALUE_WIDTH{1'b0}}, VAL_MAX} + {{(2*VALUE_WIDTH-1){1'b0}}, neg};
        if (q > limit)
        begin
            return neg ? VAL_MIN : VAL_MAX;
        end
        return neg ? -q[VALUE_WIDTH-1:0] : q[VALUE_WIDTH-1:0];
    endfunction

    function automatic value_t merge_value(merge_op_t op, value_t v, value_t u);
        value_t av;
        value_t au;
        av = sat_abs(v);
        au = sat_abs(u);
        case (op)
            OP_SUM:     return sat_add(v, u);
            OP_PRODUCT: return sat_mul(v, u);
            OP_MAX_MAG: return (av > au) ? av : au;
            OP_MIN_MAG: return (av < au) ? av : au;
            default:    return sat_add(v, u);
        endcase
    endfunction

endpackage

// File: rtl/core/sdm_in_if.sv
interface sdm_in_if;
    import sdm_pkg::*;

    logic   valid;
    logic   ready;
    index_t entry_index;
    value_t entry_value;
    logic   row_end;
    logic   no_entry;

    modport source (
        output valid,
        output entry_index,
        output entry_value,
        output row_end,
        output no_entry,
        input  ready
    );

    modport sink (
        input  valid,
        input  entry_index,
        input  entry_value,
        input  row_end,
        input  no_entry,
        output ready
    );

endinterface

// File: rtl/core/sdm_out_if.sv
interface sdm_out_if;
    import sdm_pkg::*;

    logic   valid;
    logic   ready;
    index_t out_index;
    value_t out_value;
    logic   out_row_end;
    logic   out_empty_row;
    len_t   row_length;

    modport source (
        output valid,
        output out_index,
        output out_value,
        output out_row_end,
        output out_empty_row,
        output row_length,
        input  ready
    );

    modport sink (
        input  valid,
        input  out_index,
        input  out_value,
        input  out_row_end,
        input  out_empty_row,
        input  row_length,
        output ready
    );

endinterface

// File: rtl/core/sdm_merge.sv
module sdm_merge (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  sdm_pkg::item_t    item,
    input  sdm_pkg::merge_op_t op,
    output sdm_pkg::push_t    push
);
    import sdm_pkg::*;

    index_t held_index_reg;
    index_t held_index_next;
    value_t held_value_reg;
    value_t held_value_next;
    logic   held_valid_reg;
    logic   held_valid_next;
    len_t   count_reg;
    len_t   count_next;

    logic    matched;
    value_t  merged;
    len_t    count_up;
    logic    flush;
    logic    close;
    result_t flush_res;
    result_t close_res;

    always_comb
    begin
        matched  = held_valid_reg && (item.index == held_index_reg);
        merged   = merge_value(op, held_value_reg, item.value);
        count_up = (count_reg < len_t'(MAX_ROW_LENGTH)) ? count_reg + len_t'(1) : count_reg;

        held_index_next = held_index_reg;
        held_value_next = held_value_reg;
        held_valid_next = held_valid_reg;
        count_next      = count_reg;
        flush           = 1'b0;
        close           = 1'b0;

        flush_res = '{index: held_index_reg, value: held_value_reg, row_end: 1'b0,
                      empty_row: 1'b0, length: '0};
        close_res = flush_res;

        if (fire)
        begin
            if (!item.no_entry)
            begin
                if (matched)
                begin
                    held_value_next = merged;
                end
                else
                begin
                    flush           = held_valid_reg;
                    held_index_next = item.index;
                    held_value_next = item.value;
                    held_valid_next = 1'b1;
                    count_next      = count_up;
                end
                if (item.row_end)
                begin
                    close     = 1'b1;
                    close_res = '{index: held_index_next, value: held_value_next,
                                  row_end: 1'b1, empty_row: 1'b0, length: count_next};
                    held_valid_next = 1'b0;
                    count_next      = '0;
                end
            end
            else if (item.row_end)
            begin
                close = 1'b1;
                if (held_valid_reg)
                begin
                    close_res = '{index: held_index_reg, value: held_value_reg,
                                  row_end: 1'b1, empty_row: 1'b0, length: count_reg};
                end
                else
                begin
                    close_res = '{index: '0, value: '0, row_end: 1'b1,
                                  empty_row: 1'b1, length: '0};
                end
                held_valid_next = 1'b0;
                count_next      = '0;
            end
        end

        push.n      = {1'b0, flush} + {1'b0, close};
        push.first  = flush ? flush_res : close_res;
        push.second = close_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_index_reg <= held_index_next;
        held_value_reg <= held_value_next;
    end

endmodule

// File: rtl/core/sdm_fifo.sv
module sdm_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sdm_pkg::push_t       push,
    output sdm_pkg::fifo_stat_t  stat,
    sdm_out_if.source            out_ch
);
    import sdm_pkg::*;

    result_t mem [FIFO_DEPTH];

    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] wr_ptr_plus1;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic                  pop;
    result_t               head;

    always_comb
    begin
        pop          = (count_reg != '0) && out_ch.ready;
        wr_ptr_plus1 = wr_ptr_reg + FIFO_PTR_W'(1);
        wr_ptr_next  = wr_ptr_reg + FIFO_PTR_W'(push.n);
        rd_ptr_next  = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next   = count_reg + FIFO_CNT_W'(push.n) - FIFO_CNT_W'(pop);
        head         = mem[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.n == 2'd2)
        begin
            mem[wr_ptr_plus1] <= push.second;
        end
    end

    assign stat.count    = count_reg;
    assign stat.space_ok = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));

    assign out_ch.valid         = (count_reg != '0);
    assign out_ch.out_index     = head.index;
    assign out_ch.out_value     = head.value;
    assign out_ch.out_row_end   = head.row_end;
    assign out_ch.out_empty_row = head.empty_row;
    assign out_ch.row_length    = head.length;

endmodule

// File: rtl/core/sparse_duplicate_merger_core.sv
// An accepted transaction is registered in the input stage and merged once the result queue has room;
// the results it releases are written into the result queue and offered from there. An entry is held
// until an item with another index, a row end or an empty-row close arrives. Throughput: one input
// transaction per cycle while the four-entry queue has room for two results, as an item may release two.
// Reset clears the held entry, the row count and the result queue; merge_op resets to sum.
module sparse_duplicate_merger_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sdm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sdm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sdm_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready,
    sdm_in_if.sink                        in_ch,
    sdm_out_if.source                     out_ch
);
    import sdm_pkg::*;

    merge_op_t  merge_op_reg;
    logic       in_vld_reg;
    logic       in_vld_next;
    item_t      item_reg;
    logic       fire;
    push_t      push;
    fifo_stat_t fifo_stat;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MERGE_OP) ?
                    {{(APB_DATA_W-2){1'b0}}, merge_op_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            merge_op_reg <= OP_SUM;
        end
        else if (psel && penable && pwrite && (paddr == ADDR_MERGE_OP))
        begin
            merge_op_reg <= merge_op_t'(pwdata[1:0]);
        end
    end

    assign fire        = in_vld_reg && fifo_stat.space_ok;
    assign in_ch.ready = !in_vld_reg || fire;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_ch.ready)
        begin
            in_vld_next = in_ch.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            item_reg <= '{index: in_ch.entry_index, value: in_ch.entry_value,
                          row_end: in_ch.row_end, no_entry: in_ch.no_entry};
        end
    end

    sdm_merge u_merge (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .op    (merge_op_reg),
        .push  (push)
    );

    sdm_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .stat   (fifo_stat),
        .out_ch (out_ch)
    );

    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_stat.count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_ignored_item: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item_reg.no_entry && !item_reg.row_end) |=>
        (fifo_stat.count <= $past(fifo_stat.count)))
        else $error("an item with no entry and no row end produced a result");

    a_empty_row: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.out_empty_row) |->
        (out_ch.out_row_end && (out_ch.row_length == '0) && (out_ch.out_value == '0)))
        else $error("empty-row result carries data");

    a_length_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.out_row_end) |-> (out_ch.row_length == '0))
        else $error("row length reported before the row end");

endmodule

// File: tb/sv/tb_sparse_duplicate_merger_core.sv
module tb_sparse_duplicate_merger_core;
    timeunit 1ns;
    timeprecision 1ps;

    import sdm_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 400;
    localparam int LONG_ROW    = 64;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    sdm_in_if  in_ch();
    sdm_out_if out_ch();

    sparse_duplicate_merger_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    item_t       entry_queue[$];
    result_t     merged_queue[$];
    item_t       offered;

    merge_op_t   merge_setting;
    index_t      held_idx;
    value_t      held_val;
    logic        held_ok;
    len_t        row_cnt;

    logic        gaps_on;
    int unsigned stall_token;
    int unsigned stall_seen;
    int          hold_left;
    int          quiet_cycles;
    int          items_in;
    int          results_out;
    int          errors;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic value_t abs_clamped(value_t x);
        if (x == VAL_MIN)
        begin
            return VAL_MAX;
        end
        return (x < 0) ? -x : x;
    endfunction

    function automatic value_t clamp_sum(value_t a, value_t b);
        longint s;
        longint top;
        longint bottom;
        top    = VAL_MAX;
        bottom = VAL_MIN;
        s      = longint'(a) + longint'(b);
        if (s > top)
        begin
            return VAL_MAX;
        end
        if (s < bottom)
        begin
            return VAL_MIN;
        end
        return value_t'(s);
    endfunction

    function automatic value_t clamp_product(value_t a, value_t b);
        logic        neg;
        longint      la;
        longint      lb;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] q;
        logic [63:0] limit;
        neg   = a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1];
        la    = a;
        lb    = b;
        ma    = (la < 0) ? -la : la;
        mb    = (lb < 0) ? -lb : lb;
        q     = (ma * mb) >> FRAC_BITS;
        limit = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (q > limit)
        begin
            return neg ? VAL_MIN : VAL_MAX;
        end
        return neg ? value_t'(-longint'(q)) : value_t'(q);
    endfunction

    function automatic value_t combine_values(merge_op_t op, value_t v, value_t u);
        value_t av;
        value_t au;
        av = abs_clamped(v);
        au = abs_clamped(u);
        case (op)
            OP_SUM:     return clamp_sum(v, u);
            OP_PRODUCT: return clamp_product(v, u);
            OP_MAX_MAG: return (av > au) ? av : au;
            default:    return (av < au) ? av : au;
        endcase
    endfunction

    function automatic void push_merged(index_t i, value_t v, logic last, logic empty, len_t n);
        result_t r;
        r.index     = i;
        r.value     = v;
        r.row_end   = last;
        r.empty_row = empty;
        r.length    = n;
        merged_queue.push_back(r);
    endfunction

    // Follows the held entry and row count for every accepted input transaction.
    function automatic void track_entry(item_t it);
        if (it.no_entry)
        begin
            if (!it.row_end)
            begin
                return;
            end
            if (held_ok)
            begin
                push_merged(held_idx, held_val, 1'b1, 1'b0, row_cnt);
            end
            else
            begin
                push_merged('0, '0, 1'b1, 1'b1, '0);
            end
            held_ok = 1'b0;
            row_cnt = '0;
            return;
        end
        if (held_ok && it.index == held_idx)
        begin
            held_val = combine_values(merge_setting, held_val, it.value);
        end
        else
        begin
            if (held_ok)
            begin
                push_merged(held_idx, held_val, 1'b0, 1'b0, '0);
            end
            held_idx = it.index;
            held_val = it.value;
            held_ok  = 1'b1;
            if (row_cnt < MAX_ROW_LENGTH)
            begin
                row_cnt = row_cnt + 1'b1;
            end
        end
        if (it.row_end)
        begin
            push_merged(held_idx, held_val, 1'b1, 1'b0, row_cnt);
            held_ok = 1'b0;
            row_cnt = '0;
        end
    endfunction

    function automatic value_t random_value();
        int unsigned pick;
        value_t      v;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            case ($urandom_range(4))
                0:       v = VAL_MAX;
                1:       v = VAL_MIN;
                2:       v = '0;
                3:       v = -1;
                default: v = 32'sh0001_0000;
            endcase
        end
        else if (pick < 45)
        begin
            v = value_t'($urandom_range(32'h0003_FFFF));
            if ($urandom_range(1))
            begin
                v = -v;
            end
        end
        else
        begin
            v = value_t'($urandom);
        end
        return v;
    endfunction

    task automatic add_item(index_t i, value_t v, logic last, logic none);
        item_t it;
        it.index    = i;
        it.value    = v;
        it.row_end  = last;
        it.no_entry = none;
        entry_queue.push_back(it);
    endtask

    // Mostly sorted rows with duplicate runs; a few unsorted jumps, empty rows,
    // separate close markers and ignored filler transactions.
    task automatic queue_random_rows(int count);
        int     added;
        int     len;
        int     p;
        logic   close_marker;
        index_t idx;
        added = 0;
        while (added < count)
        begin
            if ($urandom_range(99) < 8)
            begin
                add_item(index_t'($urandom), random_value(), 1'b1, 1'b1);
                added++;
            end
            else
            begin
                len          = $urandom_range(1, 10);
                close_marker = ($urandom_range(99) < 25);
                idx          = ($urandom_range(99) < 20) ? index_t'($urandom)
                                                         : index_t'($urandom_range(200));
                for (int k = 0; k < len; k++)
                begin
                    if (k > 0)
                    begin
                        p = $urandom_range(99);
                        if (p >= 90)
                        begin
                            idx = index_t'($urandom);
                        end
                        else if (p >= 40)
                        begin
                            idx = idx + index_t'($urandom_range(1, 50));
                        end
                    end
                    if ($urandom_range(99) < 4)
                    begin
                        add_item(index_t'($urandom), random_value(), 1'b0, 1'b1);
                    end
                    add_item(idx, random_value(), (k == len - 1) && !close_marker, 1'b0);
                    added++;
                end
                if (close_marker)
                begin
                    add_item(index_t'($urandom), random_value(), 1'b1, 1'b1);
                    added++;
                end
            end
        end
    endtask

    task automatic write_merge_op(merge_op_t op);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MERGE_OP;
        pwdata  <= APB_DATA_W'(op);
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        merge_setting = op;
    endtask

    task automatic wait_idle();
        do
        begin
            @(negedge clk);
        end
        while (entry_queue.size() != 0 || in_ch.valid || merged_queue.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic check_merged();
        result_t want;
        if (merged_queue.size() == 0)
        begin
            $error("unexpected transaction: out_index %0d out_value %0d",
                   out_ch.out_index, out_ch.out_value);
            errors++;
            return;
        end
        want = merged_queue.pop_front();
        if (out_ch.out_index !== want.index)
        begin
            $error("out_index: expected %0d, got %0d", want.index, out_ch.out_index);
            errors++;
        end
        if (out_ch.out_value !== want.value)
        begin
            $error("out_value: expected %0d, got %0d", want.value, out_ch.out_value);
            errors++;
        end
        if (out_ch.out_row_end !== want.row_end)
        begin
            $error("out_row_end: expected %0d, got %0d", want.row_end, out_ch.out_row_end);
            errors++;
        end
        if (out_ch.out_empty_row !== want.empty_row)
        begin
            $error("out_empty_row: expected %0d, got %0d", want.empty_row,
                   out_ch.out_empty_row);
            errors++;
        end
        if (out_ch.row_length !== want.length)
        begin
            $error("row_length: expected %0d, got %0d", want.length, out_ch.row_length);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                track_entry(offered);
                items_in++;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (entry_queue.size() != 0 && !(gaps_on && $urandom_range(99) < 6))
                begin
                    offered              = entry_queue.pop_front();
                    in_ch.valid         <= 1'b1;
                    in_ch.entry_index   <= offered.index;
                    in_ch.entry_value   <= offered.value;
                    in_ch.row_end       <= offered.row_end;
                    in_ch.no_entry      <= offered.no_entry;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            hold_left    <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                check_merged();
                results_out++;
            end
            if (stall_token != stall_seen)
            begin
                stall_seen   <= stall_token;
                hold_left    <= HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                if (hold_left != 0)
                begin
                    hold_left <= hold_left - 1;
                end
                out_ch.ready <= (hold_left <= 1) && !(gaps_on && $urandom_range(99) < 6);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timed out with %0d results still outstanding.", merged_queue.size());
            $display("sparse_duplicate_merger_core regression: fail");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        merge_op_t op;

        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_ch.valid       = 1'b0;
        in_ch.entry_index = '0;
        in_ch.entry_value = '0;
        in_ch.row_end     = 1'b0;
        in_ch.no_entry    = 1'b0;
        out_ch.ready      = 1'b0;
        merge_setting     = OP_SUM;
        held_idx          = '0;
        held_val          = '0;
        held_ok           = 1'b0;
        row_cnt           = '0;
        gaps_on           = 1'b1;
        stall_token       = 0;
        stall_seen        = 0;
        hold_left         = 0;
        quiet_cycles      = 0;
        items_in          = 0;
        results_out       = 0;
        errors            = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        write_merge_op(OP_SUM);
        @(negedge clk);
        add_item(16'd9, 32'sd77, 1'b0, 1'b1);
        add_item(16'd0, '0, 1'b1, 1'b1);
        add_item(16'd0, VAL_MAX, 1'b0, 1'b0);
        add_item(16'd0, 32'sd1, 1'b0, 1'b0);
        add_item(16'hFFFF, VAL_MIN, 1'b0, 1'b0);
        add_item(16'hFFFF, -32'sd1, 1'b0, 1'b0);
        add_item(16'h1234, '0, 1'b1, 1'b1);
        add_item(16'd5, -32'sd3, 1'b1, 1'b0);
        add_item(16'd7, 32'sd100, 1'b0, 1'b0);
        add_item(16'd3, 32'sd200, 1'b0, 1'b0);
        add_item(16'd7, 32'sd300, 1'b1, 1'b0);
        wait_idle();

        write_merge_op(OP_PRODUCT);
        @(negedge clk);
        add_item(16'd1, 32'sh0002_0000, 1'b0, 1'b0);
        add_item(16'd1, 32'sh0003_0000, 1'b0, 1'b0);
        add_item(16'd2, VAL_MIN, 1'b0, 1'b0);
        add_item(16'd2, VAL_MIN, 1'b0, 1'b0);
        add_item(16'd3, VAL_MIN, 1'b0, 1'b0);
        add_item(16'd3, 32'sh0001_0000, 1'b0, 1'b0);
        add_item(16'd4, -32'sd1, 1'b0, 1'b0);
        add_item(16'd4, 32'sd1, 1'b1, 1'b0);
        wait_idle();

        write_merge_op(OP_MAX_MAG);
        @(negedge clk);
        add_item(16'd0, VAL_MIN, 1'b0, 1'b0);
        add_item(16'd0, 32'sd5, 1'b0, 1'b0);
        add_item(16'd1, -32'sd7, 1'b0, 1'b0);
        add_item(16'd1, 32'sd3, 1'b1, 1'b0);
        wait_idle();

        write_merge_op(OP_MIN_MAG);
        @(negedge clk);
        add_item(16'd0, -32'sd7, 1'b0, 1'b0);
        add_item(16'd0, 32'sd3, 1'b0, 1'b0);
        add_item(16'd1, VAL_MIN, 1'b0, 1'b0);
        add_item(16'd1, VAL_MIN, 1'b1, 1'b0);
        wait_idle();

        for (int ph = 0; ph < 8; ph++)
        begin
            op = (ph < 4) ? merge_op_t'(ph) : merge_op_t'($urandom_range(3));
            write_merge_op(op);
            @(negedge clk);
            gaps_on = (ph != 4);
            if (ph == 5)
            begin
                stall_token++;
            end
            queue_random_rows(85);
            wait_idle();
        end
        gaps_on = 1'b1;

        write_merge_op(OP_SUM);
        @(negedge clk);
        for (int k = 0; k < LONG_ROW; k++)
        begin
            add_item(index_t'(k), random_value(), k == LONG_ROW - 1, 1'b0);
        end
        wait_idle();
        repeat (12) @(posedge clk);

        $display("Ran %0d input transactions and checked %0d merged results.",
                 items_in, results_out);
        $display("Covered all four merge rules, empty and closed rows, and a %0d-entry row.",
                 LONG_ROW);
        if (errors == 0)
        begin
            $display("sparse_duplicate_merger_core regression: pass");
        end
        else
        begin
            $display("sparse_duplicate_merger_core regression: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/sdm_pkg.sv
rtl/core/sdm_in_if.sv
rtl/core/sdm_out_if.sv
rtl/core/sdm_merge.sv
rtl/core/sdm_fifo.sv
rtl/core/sparse_duplicate_merger_core.sv
tb/sv/tb_sparse_duplicate_merger_core.sv
